### rtl/nps_pkg.sv
package nps_pkg;

  localparam int unsigned MAX_LEN = 16;
  localparam int unsigned IDX_W   = $clog2(MAX_LEN);
  localparam int unsigned VAL_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned STEPS_W = 16;
  localparam int unsigned LEN_RST = 16;

  typedef struct packed {
    logic               restart;
    logic [STEPS_W-1:0] steps;
  } nps_in_t;

  typedef struct packed {
    logic [4:0] value;
    logic [3:0] position;
    logic       last;
    logic       exhausted;
  } nps_out_t;

  typedef struct packed {
    logic             clear;
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
  } nps_mem_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_PIV_FIRST,
    ST_PIV,
    ST_SUCC,
    ST_SWAP,
    ST_REV,
    ST_REV_A,
    ST_REV_B,
    ST_REV_C,
    ST_EMIT_RD,
    ST_EMIT_WR
  } nps_state_e;

endpackage

### rtl/nps_perm_store.sv
module nps_perm_store
  import nps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nps_mem_req_t     req_i,
  output logic [VAL_W-1:0] rdata_o
);

  logic [VAL_W-1:0] perm_mem [MAX_LEN];
  logic [MAX_LEN-1:0] valid_q;
  logic [VAL_W-1:0] rd_data_q;
  logic [IDX_W-1:0] rd_addr_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.clear) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      perm_mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q  <= perm_mem[req_i.raddr];
      rd_addr_q  <= req_i.raddr;
      rd_valid_q <= valid_q[req_i.raddr];
    end
  end

  // unwritten entries read as identity order
  assign rdata_o = rd_valid_q ? rd_data_q : (VAL_W'(rd_addr_q) + VAL_W'(1));

endmodule

### rtl/next_permutation_stepper_unit.sv
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+--------------------------------
// in       | input     | in_valid_i/in_stall_o  | in_data_i  (restart, steps)
// out      | output    | out_valid_o/out_stall_i| out_data_o (value, position,
//          |           |                        |   last, exhausted)
// cfg      | input     | cfg_valid_i/cfg_ready_o| cfg_data_i (length)
//
// One item at a time. Each advance is bound by the single read port of the
// permutation store (pivot scan, successor scan, pairwise suffix reversal);
// emission reads each element from the store, then presents it.
// Reset sets length to 16 and the store to identity via per-entry valid bits;
// restart clears those bits as its item is accepted. A stalled output holds the
// emit sequence; the next item is taken while the last result still waits.
module next_permutation_stepper_unit
  import nps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  nps_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output nps_out_t         out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  nps_state_e         state_q, state_d;
  nps_mem_req_t       mem_req;
  logic [VAL_W-1:0]   rdata;
  logic [CFG_W-1:0]   len_q;
  logic [LEN_W-1:0]   n_q, wl;
  logic [STEPS_W-1:0] cnt_q;
  logic [IDX_W-1:0]   ptr_q, p_q, q_q, lo_q, hi_q, e_q, nm1;
  logic [VAL_W-1:0]   prev_q, pv_q, tmp_q;
  logic               exh_q;
  logic               out_valid_q;
  nps_out_t           out_data_q;
  logic               accept, out_free, piv_hit, succ_hit;

  nps_perm_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign nm1         = IDX_W'(n_q - LEN_W'(1));
  assign piv_hit     = rdata < prev_q;
  assign succ_hit    = rdata > pv_q;

  always_comb begin
    if (len_q == '0) begin
      wl = LEN_W'(1);
    end else if (32'(len_q) > MAX_LEN) begin
      wl = LEN_W'(MAX_LEN);
    end else begin
      wl = LEN_W'(len_q);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (accept) state_d = ST_CHK;
      ST_CHK: begin
        if (cnt_q == '0 || n_q == LEN_W'(1)) state_d = ST_EMIT_RD;
        else state_d = ST_PIV_FIRST;
      end
      ST_PIV_FIRST: state_d = ST_PIV;
      ST_PIV: begin
        if (piv_hit) state_d = ST_SUCC;
        else if (ptr_q == '0) state_d = ST_EMIT_RD;
      end
      ST_SUCC:      if (succ_hit) state_d = ST_SWAP;
      ST_SWAP:      state_d = ST_REV;
      ST_REV:       state_d = (lo_q < hi_q) ? ST_REV_A : ST_CHK;
      ST_REV_A:     state_d = ST_REV_B;
      ST_REV_B:     state_d = ST_REV_C;
      ST_REV_C:     state_d = ST_REV;
      ST_EMIT_RD:   state_d = ST_EMIT_WR;
      ST_EMIT_WR: begin
        if (out_free) state_d = (e_q == nm1) ? ST_IDLE : ST_EMIT_RD;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_req = '0;
    unique case (state_q)
      ST_IDLE:      mem_req.clear = accept && in_data_i.restart;
      ST_CHK: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = nm1;
      end
      ST_PIV_FIRST: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = ptr_q;
      end
      ST_PIV: begin
        if (piv_hit) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = nm1;
        end else if (ptr_q != '0) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ptr_q - IDX_W'(1);
        end
      end
      ST_SUCC: begin
        if (succ_hit) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = p_q;
          mem_req.wdata = rdata;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ptr_q - IDX_W'(1);
        end
      end
      ST_SWAP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = q_q;
        mem_req.wdata = pv_q;
      end
      ST_REV: begin
        mem_req.re    = lo_q < hi_q;
        mem_req.raddr = lo_q;
      end
      ST_REV_A: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = hi_q;
      end
      ST_REV_B: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = lo_q;
        mem_req.wdata = rdata;
      end
      ST_REV_C: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = hi_q;
        mem_req.wdata = tmp_q;
      end
      ST_EMIT_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = e_q;
      end
      ST_EMIT_WR:   mem_req = '0;
      default:      mem_req = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= CFG_W'(LEN_RST);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        len_q <= cfg_data_i;
      end
      if (state_q == ST_EMIT_WR && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_q <= in_data_i.steps;
          n_q   <= wl;
          exh_q <= 1'b0;
          e_q   <= '0;
        end
      end
      ST_CHK: begin
        ptr_q <= nm1 - IDX_W'(1);
        if (cnt_q != '0 && n_q == LEN_W'(1)) exh_q <= 1'b1;
      end
      ST_PIV_FIRST: prev_q <= rdata;
      ST_PIV: begin
        if (piv_hit) begin
          p_q   <= ptr_q;
          pv_q  <= rdata;
          ptr_q <= nm1;
        end else begin
          prev_q <= rdata;
          if (ptr_q == '0) exh_q <= 1'b1;
          else ptr_q <= ptr_q - IDX_W'(1);
        end
      end
      ST_SUCC: begin
        if (succ_hit) begin
          q_q  <= ptr_q;
          lo_q <= p_q + IDX_W'(1);
          hi_q <= nm1;
        end else begin
          ptr_q <= ptr_q - IDX_W'(1);
        end
      end
      ST_SWAP:  tmp_q <= tmp_q;
      ST_REV:   if (!(lo_q < hi_q)) cnt_q <= cnt_q - STEPS_W'(1);
      ST_REV_A: tmp_q <= rdata;
      ST_REV_B: tmp_q <= tmp_q;
      ST_REV_C: begin
        lo_q <= lo_q + IDX_W'(1);
        hi_q <= hi_q - IDX_W'(1);
      end
      ST_EMIT_RD: e_q <= e_q;
      ST_EMIT_WR: begin
        if (out_free) begin
          out_data_q.value     <= 5'(rdata);
          out_data_q.position  <= 4'(e_q);
          out_data_q.last      <= (e_q == nm1);
          out_data_q.exhausted <= exh_q;
          if (e_q != nm1) e_q <= e_q + IDX_W'(1);
        end
      end
      default: e_q <= e_q;
    endcase
  end

  a_no_rw_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.we && mem_req.re && mem_req.waddr == mem_req.raddr))
    else $error("store read and write hit the same entry");

  a_rev_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REV_B |-> lo_q < hi_q)
    else $error("suffix reversal pointers crossed");

  a_succ_right_of_pivot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SUCC |-> ptr_q > p_q)
    else $error("successor scan passed the pivot");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_WR && out_valid_q && out_stall_i) |=> state_q == ST_EMIT_WR)
    else $error("emit advanced while output stalled");

endmodule
